[hdl/fvcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvcc_pkg
// Widths, constants and hue tables for the flow vector color coder.
// ----------------------------------------------------------------------------
package fvcc_pkg;

	localparam int FLOW_W       = 16;
	localparam int SCALE_W      = 24;
	localparam int PROD_W       = FLOW_W + SCALE_W + 1;
	localparam int AMP_FRAC     = 24;
	localparam int AMP_W        = AMP_FRAC + 1;
	localparam int SQ_W         = 2 * AMP_FRAC + 2;
	localparam int SQRT_STEPS   = AMP_FRAC + 1;
	localparam int NORM_TOP     = 52;
	localparam int MAG_W        = (PROD_W > NORM_TOP + 1) ? PROD_W : NORM_TOP + 1;
	localparam int CX_W         = MAG_W + 4;
	localparam int CORDIC_STEPS = 15;
	localparam int ANG_W        = 16;
	localparam int Z_W          = ANG_W + 1;
	localparam int COLOR_W      = 8;
	localparam int HUE_LOG2W    = 14;
	localparam int MIX_W        = COLOR_W + HUE_LOG2W;
	localparam int MUL_W        = AMP_W + MIX_W;
	localparam int HUE_SHIFT    = AMP_FRAC + HUE_LOG2W;
	localparam int APB_AW       = 3;

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
	localparam logic [APB_AW-1:0]  REG_SCALE   = '0;
	localparam logic [ANG_W-1:0]   ANG_UP      = ANG_W'(16384);
	localparam logic [ANG_W-1:0]   ANG_DOWN    = ANG_W'(49152);
	localparam logic [AMP_W-1:0]   AMP_ONE     = AMP_W'(1) << AMP_FRAC;

	typedef struct packed {
		logic sat;
		logic xz;
		logic ypos;
		logic neg;
	} flag_t;

	typedef struct packed {
		logic signed [CX_W-1:0] cx;
		logic signed [CX_W-1:0] cy;
		logic [MAG_W-1:0]       m;
	} norm_t;

	typedef struct packed {
		logic [SQ_W-1:0]        rem;
		logic [SQ_W:0]          root;
		logic signed [CX_W-1:0] cx;
		logic signed [CX_W-1:0] cy;
		logic signed [Z_W-1:0]  z;
		flag_t                  fl;
	} iter_t;

	function automatic logic [Z_W-1:0] atan_unit(input int unsigned i);
		logic [Z_W-1:0] r;
		unique case (i)
			0:       r = Z_W'(8192);
			1:       r = Z_W'(4836);
			2:       r = Z_W'(2555);
			3:       r = Z_W'(1297);
			4:       r = Z_W'(651);
			5:       r = Z_W'(326);
			6:       r = Z_W'(163);
			7:       r = Z_W'(81);
			8:       r = Z_W'(41);
			9:       r = Z_W'(20);
			10:      r = Z_W'(10);
			11:      r = Z_W'(5);
			12:      r = Z_W'(3);
			default: r = Z_W'(1);
		endcase
		return r;
	endfunction

	// start color of a hue segment, channel 0 red, 1 green, 2 blue
	function automatic logic [COLOR_W-1:0] seg_c0(input logic [2:0] s, input logic [1:0] c);
		logic [3*COLOR_W-1:0] rgb;
		unique case (s)
			3'd0:    rgb = {8'd0,   8'd0,   8'd255};
			3'd1:    rgb = {8'd255, 8'd0,   8'd255};
			3'd2:    rgb = {8'd255, 8'd64,  8'd64};
			3'd3:    rgb = {8'd255, 8'd255, 8'd0};
			3'd4:    rgb = {8'd0,   8'd255, 8'd0};
			default: rgb = {8'd0,   8'd255, 8'd255};
		endcase
		return rgb[c*COLOR_W +: COLOR_W];
	endfunction

	// end minus start color of a hue segment
	function automatic logic signed [COLOR_W:0] seg_d(input logic [2:0] s, input logic [1:0] c);
		logic signed [3*(COLOR_W+1)-1:0] rgb;
		unique case (s)
			3'd0:    rgb = {9'sd255,  9'sd0,   9'sd0};
			3'd1:    rgb = {9'sd0,    9'sd64,  -9'sd191};
			3'd2:    rgb = {9'sd0,    9'sd191, -9'sd64};
			3'd3:    rgb = {-9'sd255, 9'sd0,   9'sd0};
			3'd4:    rgb = {9'sd0,    9'sd0,   9'sd255};
			default: rgb = {9'sd0,    -9'sd255, 9'sd0};
		endcase
		return rgb[c*(COLOR_W+1) +: (COLOR_W+1)];
	endfunction

endpackage

[hdl/flow_vector_color_coder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_vector_color_coder
// Maps one flow vector per beat to an RGB color on the flow color wheel.
// ----------------------------------------------------------------------------
// channel  direction  beat contents
// s_axis   in         tdata: flow_u, flow_v
// m_axis   out        tdata: red, green, blue
// apb      in/out     inverse_max_disp at byte address 0
//
// One beat per cycle sustained while the output does not stall; m_tvalid rises
// after the input beat has passed four front stages, 26 square root stages (the
// CORDIC steps run beside them), four hue stages and the output register.
// arst_n clears all valid bits and loads the scale register with 1.0.
// An output stall parks at most one beat in the skid entry; while it is full
// s_tready is low and the whole pipeline holds.
// ----------------------------------------------------------------------------
module flow_vector_color_coder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [2*fvcc_pkg::FLOW_W-1:0]   s_tdata,  // flow_u, flow_v
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [3*fvcc_pkg::COLOR_W-1:0]  m_tdata,  // red, green, blue
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fvcc_pkg::APB_AW-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import fvcc_pkg::*;

	logic [SCALE_W-1:0] scale_q;
	logic               en;

	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == REG_SCALE[APB_AW-1:2]) ? 32'(scale_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[APB_AW-1:2] == REG_SCALE[APB_AW-1:2]) begin
			scale_q <= pwdata[SCALE_W-1:0];
		end
	end

	function automatic norm_t norm_shift(input norm_t n, input int unsigned k);
		norm_t r;
		r = n;
		if ((n.m >> (NORM_TOP + 1 - k)) == '0) begin
			r.m  = n.m << k;
			r.cx = n.cx <<< k;
			r.cy = n.cy <<< k;
		end
		return r;
	endfunction

	// stage 1: scale
	logic                     v_s1;
	logic signed [PROD_W-1:0] x_s1, y_s1;
	// stage 2: sign fold
	logic                     v_s2;
	logic [PROD_W-1:0]        ax_s2, ay_s2;
	flag_t                    fl_s2;
	norm_t                    n_s2;
	// stage 3: squares
	logic                     v_s3;
	logic [2*AMP_FRAC-1:0]    sqx_s3, sqy_s3;
	flag_t                    fl_s3;
	norm_t                    n_s3;
	// stage 4: sum
	logic                     v_s4;
	logic [SQ_W-1:0]          sum_s4;
	flag_t                    fl_s4;
	norm_t                    n_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		norm_t n2;
		n2 = '0;
		if (en) begin
			x_s1 <= PROD_W'($signed(s_tdata[FLOW_W-1:0]) * $signed({1'b0, scale_q}));
			y_s1 <= PROD_W'($signed(s_tdata[2*FLOW_W-1:FLOW_W]) * $signed({1'b0, scale_q}));

			ax_s2 <= x_s1[PROD_W-1] ? PROD_W'(-x_s1) : PROD_W'(x_s1);
			ay_s2 <= y_s1[PROD_W-1] ? PROD_W'(-y_s1) : PROD_W'(y_s1);
			fl_s2.sat  <= 1'b0;
			fl_s2.xz   <= (x_s1 == '0);
			fl_s2.ypos <= !y_s1[PROD_W-1];
			fl_s2.neg  <= x_s1[PROD_W-1];
			n2.cx = x_s1[PROD_W-1] ? -CX_W'(x_s1) : CX_W'(x_s1);
			n2.cy = x_s1[PROD_W-1] ? -CX_W'(y_s1) : CX_W'(y_s1);
			n2.m  = MAG_W'(x_s1[PROD_W-1] ? PROD_W'(-x_s1) : PROD_W'(x_s1))
				| MAG_W'(y_s1[PROD_W-1] ? PROD_W'(-y_s1) : PROD_W'(y_s1));
			n_s2 <= n2;

			sqx_s3 <= ax_s2[AMP_FRAC-1:0] * ax_s2[AMP_FRAC-1:0];
			sqy_s3 <= ay_s2[AMP_FRAC-1:0] * ay_s2[AMP_FRAC-1:0];
			fl_s3.xz   <= fl_s2.xz;
			fl_s3.ypos <= fl_s2.ypos;
			fl_s3.neg  <= fl_s2.neg;
			fl_s3.sat  <= (ax_s2 >> AMP_FRAC) != '0 || (ay_s2 >> AMP_FRAC) != '0;
			n_s3   <= norm_shift(norm_shift(n_s2, 32), 16);

			sum_s4 <= SQ_W'(sqx_s3) + SQ_W'(sqy_s3);
			fl_s4  <= fl_s3;
			n_s4   <= norm_shift(norm_shift(n_s3, 8), 4);
		end
	end

	// iteration stages: one square root bit each, and one CORDIC step in each of the first CORDIC_STEPS
	logic  iv_s [0:SQRT_STEPS];
	iter_t it_s [0:SQRT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_s[0] <= 1'b0;
		end else if (en) begin
			iv_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		norm_t n5;
		n5 = norm_shift(norm_shift(n_s4, 2), 1);
		if (en) begin
			it_s[0].rem  <= sum_s4;
			it_s[0].root <= '0;
			it_s[0].cx   <= n5.cx;
			it_s[0].cy   <= n5.cy;
			it_s[0].z    <= '0;
			it_s[0].fl   <= fl_s4;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_iter
		localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * (SQRT_STEPS - 1 - k));
		iter_t nxt;
		logic [SQ_W:0] trial;

		always_comb begin
			nxt   = it_s[k];
			trial = it_s[k].root + BIT;
			if ({1'b0, it_s[k].rem} >= trial) begin
				nxt.rem  = it_s[k].rem - trial[SQ_W-1:0];
				nxt.root = (it_s[k].root >> 1) + BIT;
			end else begin
				nxt.root = it_s[k].root >> 1;
			end
			if (k < CORDIC_STEPS) begin
				if (!it_s[k].cy[CX_W-1]) begin
					nxt.cx = it_s[k].cx + (it_s[k].cy >>> k);
					nxt.cy = it_s[k].cy - (it_s[k].cx >>> k);
					nxt.z  = it_s[k].z + $signed(atan_unit(k));
				end else begin
					nxt.cx = it_s[k].cx - (it_s[k].cy >>> k);
					nxt.cy = it_s[k].cy + (it_s[k].cx >>> k);
					nxt.z  = it_s[k].z - $signed(atan_unit(k));
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				iv_s[k+1] <= 1'b0;
			end else if (en) begin
				iv_s[k+1] <= iv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_s[k+1] <= nxt;
			end
		end
	end

	// hue stages
	logic                     v_h1, v_h2, v_h3, v_h4;
	logic [AMP_W-1:0]         amp_h1, amp_h2;
	logic [ANG_W-1:0]         a_h1;
	logic [2:0][MIX_W-1:0]    mix_h2;
	logic [2:0][MUL_W-1:0]    mul_h3;
	logic [3*COLOR_W-1:0]     rgb_h4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_h1 <= 1'b0;
			v_h2 <= 1'b0;
			v_h3 <= 1'b0;
			v_h4 <= 1'b0;
		end else if (en) begin
			v_h1 <= iv_s[SQRT_STEPS];
			v_h2 <= v_h1;
			v_h3 <= v_h2;
			v_h4 <= v_h3;
		end
	end

	always_ff @(posedge clk) begin
		iter_t                   fin;
		logic [2:0]              seg;
		logic [HUE_LOG2W-1:0]    g;
		logic signed [MIX_W+1:0] mx;
		logic [MUL_W-HUE_SHIFT-1:0] v;
		fin = it_s[SQRT_STEPS];
		seg = a_h1[ANG_W-1] ? (a_h1[ANG_W-2] ? 3'd5 : 3'd4) : a_h1[ANG_W-1:ANG_W-3];
		g   = a_h1[ANG_W-1] ? a_h1[HUE_LOG2W-1:0] : {a_h1[HUE_LOG2W-2:0], 1'b0};
		mx  = '0;
		v   = '0;
		if (en) begin
			if (fin.fl.sat || fin.root > (SQ_W+1)'(AMP_ONE)) begin
				amp_h1 <= AMP_ONE;
			end else begin
				amp_h1 <= fin.root[AMP_W-1:0];
			end
			if (fin.fl.xz) begin
				a_h1 <= fin.fl.ypos ? ANG_UP : ANG_DOWN;
			end else begin
				a_h1 <= {fin.fl.neg, {(ANG_W-1){1'b0}}} + fin.z[ANG_W-1:0];
			end

			amp_h2 <= amp_h1;
			for (int c = 0; c < 3; c++) begin
				mx = $signed({2'b00, seg_c0(seg, 2'(c)), {HUE_LOG2W{1'b0}}})
					+ (MIX_W+2)'(seg_d(seg, 2'(c)) * $signed({1'b0, g}));
				mix_h2[c] <= mx[MIX_W-1:0];
			end

			for (int c = 0; c < 3; c++) begin
				mul_h3[c] <= amp_h2 * mix_h2[c];
			end

			for (int c = 0; c < 3; c++) begin
				v = mul_h3[c][MUL_W-1:HUE_SHIFT];
				rgb_h4[c*COLOR_W +: COLOR_W] <= (v > (MUL_W-HUE_SHIFT)'(255))
					? {COLOR_W{1'b1}} : v[COLOR_W-1:0];
			end
		end
	end

	// output register with skid entry
	logic                 skid_v_q;
	logic [3*COLOR_W-1:0] skid_q;
	logic                 deliver;

	assign en       = !skid_v_q;
	assign s_tready = en;
	assign deliver  = en && v_h4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (!m_tvalid || m_tready) begin
				m_tvalid <= deliver;
			end else if (deliver) begin
				skid_v_q <= 1'b1;
			end
		end else if (m_tready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (!m_tvalid || m_tready) begin
				m_tdata <= rgb_h4;
			end else if (deliver) begin
				skid_q <= rgb_h4;
			end
		end else if (m_tready) begin
			m_tdata <= skid_q;
		end
	end

endmodule

[verif/tb_flow_vector_color_coder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flow_vector_color_coder
// Streams flow vectors through the color coder under several scale settings,
// predicts each color with a bit-accurate fixed-point model of the wheel and
// compares every output beat in order, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_flow_vector_color_coder;
	import fvcc_pkg::*;

	localparam int LATENCY     = 35;
	localparam int WATCH_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // flow_u, flow_v
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // red, green, blue
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	rgb_t        color_queue[$];
	logic [23:0] scale_reg;
	int          mismatches;
	int          watch_cnt;
	bit          out_random;

	flow_vector_color_coder uut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint floor_shift(input longint v, input int s);
		if (v >= 0)
			return v >>> s;
		return -((-v - 1) >>> s) - 1;
	endfunction

	function automatic longint wheel_angle(input longint x0, input longint y0);
		longint x, y, z, base, dx, dy;
		longint tbl[15];
		tbl = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
		x = x0;
		y = y0;
		z = 0;
		base = 0;
		if (x == 0)
			return (y >= 0) ? 16384 : 49152;
		if (x < 0) begin
			x = -x;
			y = -y;
			base = 32768;
		end
		while (x < (64'sd1 << 52) && (y < 0 ? -y : y) < (64'sd1 << 52)) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < 15; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += tbl[i];
			end else begin
				x -= dx;
				y += dy;
				z -= tbl[i];
			end
		end
		return (base + z) & 64'hFFFF;
	endfunction

	function automatic longint vector_magnitude(input longint x, input longint y);
		longint one;
		logic [63:0] n, res, b;
		one = 64'sd1 << 24;
		if (x < 0)
			x = -x;
		if (y < 0)
			y = -y;
		if (x >= one || y >= one)
			return one;
		n = x * x + y * y;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return (res > one) ? one : longint'(res);
	endfunction

	function automatic rgb_t wheel_color(input logic signed [15:0] u,
			input logic signed [15:0] v);
		int     starts[6];
		int     lw[6];
		int     c0[6][3];
		int     c1[6][3];
		longint x, y, amp, ang, f, mix, val;
		int     s;
		logic [7:0] ch[3];
		rgb_t   r;
		starts = '{0, 8192, 16384, 24576, 32768, 49152};
		lw = '{13, 13, 13, 13, 14, 14};
		c0 = '{'{255,0,0}, '{255,0,255}, '{64,64,255}, '{0,255,255}, '{0,255,0},
			'{255,255,0}};
		c1 = '{'{255,0,255}, '{64,64,255}, '{0,255,255}, '{0,255,0}, '{255,255,0},
			'{255,0,0}};
		x = longint'(u) * longint'(scale_reg);
		y = longint'(v) * longint'(scale_reg);
		amp = vector_magnitude(x, y);
		ang = wheel_angle(x, y);
		s = 5;
		while (s > 0 && ang < starts[s])
			s--;
		f = ang - starts[s];
		for (int c = 0; c < 3; c++) begin
			mix = longint'(c0[s][c]) * (64'sd1 << lw[s]) + longint'(c1[s][c] - c0[s][c]) * f;
			val = (amp * mix) >>> (24 + lw[s]);
			if (val > 255)
				val = 255;
			if (val < 0)
				val = 0;
			ch[c] = val[7:0];
		end
		r.red = ch[0];
		r.green = ch[1];
		r.blue = ch[2];
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(9) < 6)
			return 0;
		if ($urandom_range(9) < 8)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic send_flow(input logic [15:0] u, input logic [15:0] v);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {v, u};
		color_queue.push_back(wheel_color(u, v));
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (color_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_scale(input logic [23:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= REG_SCALE;
		pwdata  <= {8'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		scale_reg = val;
	endtask

	task automatic test_directed();
		logic [15:0] pts[12];
		pts = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0100,
			16'hFF00, 16'h0080, 16'h5555, 16'hAAAA, 16'h0040, 16'hFFC0};
		send_flow(16'h0000, 16'h0000);
		send_flow(16'h7FFF, 16'h7FFF);
		send_flow(16'h8000, 16'h8000);
		send_flow(16'h0000, 16'h0100);
		send_flow(16'h0000, 16'hFF00);
		send_flow(16'h0100, 16'h0000);
		send_flow(16'hFF00, 16'h0000);
		for (int i = 0; i < 12; i++)
			send_flow(pts[i], pts[11 - i]);
	endtask

	task automatic test_wheel_sweep();
		int ang;
		real rad;
		for (int i = 0; i < 48; i++) begin
			rad = 6.283185307 * i / 48.0;
			ang = $urandom_range(255, 20);
			send_flow(16'($rtoi(ang * $cos(rad))), 16'($rtoi(ang * $sin(rad))));
		end
	endtask

	task automatic test_random(input int n);
		logic [15:0] u, v;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: begin
					u = $urandom;
					v = $urandom;
				end
				1: begin
					u = 16'($signed(10'($urandom)));
					v = 16'($signed(10'($urandom)));
				end
				default: begin
					u = 16'($signed(13'($urandom)));
					v = 16'($signed(13'($urandom)));
				end
			endcase
			send_flow(u, v);
		end
	endtask

	task automatic test_scales();
		logic [23:0] vals[5];
		vals = '{24'd0, 24'hFFFFFF, 24'd256, 24'd4096, 24'h00_8000};
		foreach (vals[i]) begin
			drain();
			write_scale(vals[i]);
			test_directed();
			test_random(90);
		end
		drain();
		write_scale(24'($urandom));
		test_random(60);
		drain();
		write_scale(24'd65536);
	endtask

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= out_random ? (gap_len() == 0) : 1'b1;
		if (arst_n && m_tvalid && m_tready) begin
			if (color_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected color beat %h", m_tdata);
			end else begin
				rgb_t e;
				e = color_queue.pop_front();
				if (m_tdata !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("color mismatch: exp r%0d g%0d b%0d got r%0d g%0d b%0d",
							e.red, e.green, e.blue, m_tdata[7:0], m_tdata[15:8],
							m_tdata[23:16]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			watch_cnt <= 0;
		else
			watch_cnt <= watch_cnt + 1;
		if (watch_cnt > WATCH_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		scale_reg = 24'd65536;
		mismatches = 0;
		watch_cnt = 0;
		out_random = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_wheel_sweep();
		out_random = 1'b1;
		test_random(250);
		drain();
		out_random = 1'b0;
		test_random(40);
		out_random = 1'b1;
		test_scales();
		drain();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
hdl/fvcc_pkg.sv
hdl/flow_vector_color_coder.sv
verif/tb_flow_vector_color_coder.sv
